### design/rbsi_pkg.sv
package rbsi_pkg;

   localparam int DATA_W        = 32;
   localparam int EXT_W         = 31;
   localparam int TOL_W         = 16;
   localparam int NUM_W         = 34;
   localparam int HI_W          = 33;
   localparam int FACE_W        = 3;
   localparam int NUM_AXES      = 3;
   localparam int NUM_FACES     = 6;
   localparam int CSR_IDX_W     = 3;
   localparam int FRAC_BITS_DEF = 16;

   // divider: input prep, one quotient bit per stage, output saturation
   localparam int DIV_LAT  = DATA_W + 2;
   // face unit: multiply, point, bounds test
   localparam int FACE_LAT = 3;
   // input register + divider + face unit + face select
   localparam int TOTAL_LAT = 1 + DIV_LAT + FACE_LAT + 1;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXT_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EXT_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_EXT_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TOL   = 3'd6;

   localparam logic [EXT_W-1:0] EXT_RESET = 31'd65536;
   localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

   typedef struct packed {
      logic                     cand;
      logic signed [DATA_W-1:0] t;
      logic signed [DATA_W-1:0] px;
      logic signed [DATA_W-1:0] py;
      logic signed [DATA_W-1:0] pz;
   } face_res_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] ox;
      logic signed [DATA_W-1:0] oy;
      logic signed [DATA_W-1:0] oz;
      logic signed [DATA_W-1:0] dx;
      logic signed [DATA_W-1:0] dy;
      logic signed [DATA_W-1:0] dz;
   } ray_type;

endpackage

### design/rbsi_div.sv
module rbsi_div #(
   parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic signed [rbsi_pkg::NUM_W-1:0]   num,
   input  logic signed [rbsi_pkg::DATA_W-1:0]  den,
   output logic signed [rbsi_pkg::DATA_W-1:0]  quo
);
   import rbsi_pkg::*;

   localparam int STEPS = DATA_W;
   localparam int RW    = (NUM_W + FRAC_BITS > 2 * DATA_W - 1) ?
                          NUM_W + FRAC_BITS : 2 * DATA_W - 1;

   logic [RW-1:0]     rem_ff [STEPS+1];
   logic [DATA_W-1:0] den_ff [STEPS+1];
   logic [DATA_W-1:0] q_ff   [STEPS+1];
   logic              neg_ff [STEPS+1];
   logic signed [DATA_W-1:0] quo_ff;
   logic signed [DATA_W-1:0] quo_in;

   logic [NUM_W-1:0]  num_mag;
   logic [DATA_W-1:0] den_mag;

   assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
   assign den_mag = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);

   // magnitude prep
   always_ff @(posedge clock) begin
      rem_ff[0] <= RW'(num_mag) << FRAC_BITS;
      den_ff[0] <= den_mag;
      q_ff[0]   <= '0;
      neg_ff[0] <= num[NUM_W-1] ^ den[DATA_W-1];
   end

   // restoring steps, msb first; a set top bit means saturation
   for (genvar j = 0; j < STEPS; j++) begin : g_step
      localparam int K = STEPS - 1 - j;
      logic [RW-1:0] dsh;
      logic          ge;
      assign dsh = RW'(den_ff[j]) << K;
      assign ge  = rem_ff[j] >= dsh;
      always_ff @(posedge clock) begin
         rem_ff[j+1] <= ge ? rem_ff[j] - dsh : rem_ff[j];
         den_ff[j+1] <= den_ff[j];
         q_ff[j+1]   <= q_ff[j] | (DATA_W'(ge) << K);
         neg_ff[j+1] <= neg_ff[j];
      end
   end

   always_comb begin
      if (q_ff[STEPS][DATA_W-1]) begin
         quo_in = neg_ff[STEPS] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else if (neg_ff[STEPS]) begin
         quo_in = -$signed({1'b0, q_ff[STEPS][DATA_W-2:0]});
      end else begin
         quo_in = $signed({1'b0, q_ff[STEPS][DATA_W-2:0]});
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
   end

   assign quo = quo_ff;

endmodule

### design/rbsi_face.sv
module rbsi_face #(
   parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               ok,
   input  logic signed [rbsi_pkg::DATA_W-1:0] t,
   input  rbsi_pkg::ray_type                  ray,
   input  logic signed [rbsi_pkg::DATA_W-1:0] lo [3],
   input  logic signed [rbsi_pkg::HI_W-1:0]   hi [3],
   input  logic        [rbsi_pkg::TOL_W-1:0]  tol,
   output rbsi_pkg::face_res_type             res
);
   import rbsi_pkg::*;

   localparam int PW = 2 * DATA_W;

   logic signed [DATA_W-1:0] org [NUM_AXES];
   logic signed [DATA_W-1:0] dir [NUM_AXES];

   logic signed [PW-1:0]     prod_ff [NUM_AXES];
   logic signed [DATA_W-1:0] o1_ff   [NUM_AXES];
   logic signed [DATA_W-1:0] t1_ff, t2_ff;
   logic                     ok1_ff, ok2_ff;
   logic signed [DATA_W-1:0] pt2_ff  [NUM_AXES];
   logic signed [DATA_W-1:0] pt_in   [NUM_AXES];
   logic                     in_axis [NUM_AXES];
   face_res_type             res_ff;

   assign org[0] = ray.ox;
   assign org[1] = ray.oy;
   assign org[2] = ray.oz;
   assign dir[0] = ray.dx;
   assign dir[1] = ray.dy;
   assign dir[2] = ray.dz;

   // products of distance and direction
   always_ff @(posedge clock) begin
      for (int a = 0; a < NUM_AXES; a++) begin
         prod_ff[a] <= PW'(t) * PW'(dir[a]);
         o1_ff[a]   <= org[a];
      end
      t1_ff  <= t;
      ok1_ff <= ok && (t > 0);
   end

   // floor shift, add origin, saturate
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         logic signed [PW:0] sum;
         sum = (PW+1)'(prod_ff[a] >>> FRAC_BITS) + (PW+1)'(o1_ff[a]);
         if (sum > (PW+1)'(64'sd2147483647))
            pt_in[a] = {1'b0, {(DATA_W-1){1'b1}}};
         else if (sum < (PW+1)'(-64'sd2147483648))
            pt_in[a] = {1'b1, {(DATA_W-1){1'b0}}};
         else
            pt_in[a] = sum[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      pt2_ff <= pt_in;
      t2_ff  <= t1_ff;
      ok2_ff <= ok1_ff;
   end

   // widened strict bounds test
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         logic signed [HI_W+1:0] lo_b;
         logic signed [HI_W+1:0] hi_b;
         lo_b = (HI_W+2)'(lo[a]) - $signed((HI_W+2)'(tol));
         hi_b = (HI_W+2)'(hi[a]) + $signed((HI_W+2)'(tol));
         in_axis[a] = ((HI_W+2)'(pt2_ff[a]) > lo_b) && ((HI_W+2)'(pt2_ff[a]) < hi_b);
      end
   end

   always_ff @(posedge clock) begin
      res_ff.cand <= ok2_ff && in_axis[0] && in_axis[1] && in_axis[2];
      res_ff.t    <= t2_ff;
      res_ff.px   <= pt2_ff[0];
      res_ff.py   <= pt2_ff[1];
      res_ff.pz   <= pt2_ff[2];
   end

   assign res = res_ff;

endmodule

### design/ray_box_slab_intersect.sv
// ray versus axis-aligned box, slab method, Q16.16 fixed point (FRAC_BITS fraction bits).
// a ray transaction is taken on any clock with start high and busy low; busy is only high
// during reset, so a new ray can enter every cycle. exactly one response per ray comes out,
// marked by rsp_valid for one cycle, in order. the receiver cannot stall, so nothing is held
// back. the latency is set by the six slab distance dividers, which produce one quotient bit
// per pipeline stage, followed by the point multiply, point saturate, bounds test and
// nearest-face select stages. box registers are written through the csr port and must only
// change while no ray is in flight.
module ray_box_slab_intersect #(
   parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [rbsi_pkg::DATA_W-1:0]   req_origin_x,
   input  logic signed [rbsi_pkg::DATA_W-1:0]   req_origin_y,
   input  logic signed [rbsi_pkg::DATA_W-1:0]   req_origin_z,
   input  logic signed [rbsi_pkg::DATA_W-1:0]   req_dir_x,
   input  logic signed [rbsi_pkg::DATA_W-1:0]   req_dir_y,
   input  logic signed [rbsi_pkg::DATA_W-1:0]   req_dir_z,
   input  logic        [rbsi_pkg::EXT_W-1:0]    req_nearest_in,
   output logic                                 rsp_valid,
   output logic                                 rsp_hit,
   output logic        [rbsi_pkg::EXT_W-1:0]    rsp_nearest_out,
   output logic signed [rbsi_pkg::DATA_W-1:0]   rsp_point_x,
   output logic signed [rbsi_pkg::DATA_W-1:0]   rsp_point_y,
   output logic signed [rbsi_pkg::DATA_W-1:0]   rsp_point_z,
   output logic        [rbsi_pkg::FACE_W-1:0]   rsp_face,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic        [rbsi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [rbsi_pkg::DATA_W-1:0]   csr_data
);
   import rbsi_pkg::*;

   localparam int NL = DIV_LAT + FACE_LAT;

   // box registers
   logic signed [DATA_W-1:0] min_ff [NUM_AXES];
   logic        [EXT_W-1:0]  ext_ff [NUM_AXES];
   logic        [TOL_W-1:0]  tol_ff;
   logic signed [HI_W-1:0]   hi     [NUM_AXES];

   // input stage
   logic                     v1_ff;
   ray_type                  ray1_ff;
   logic        [EXT_W-1:0]  near1_ff;
   logic signed [DATA_W-1:0] org1   [NUM_AXES];
   logic signed [DATA_W-1:0] dir1   [NUM_AXES];

   // side pipes that run alongside the dividers and face units
   ray_type                  ray_pipe_ff  [DIV_LAT];
   logic        [EXT_W-1:0]  near_pipe_ff [NL];
   logic                     v_pipe_ff    [NL];

   logic signed [DATA_W-1:0] t_div    [NUM_FACES];
   logic                     axis_ok  [NUM_AXES];
   face_res_type             face_res [NUM_FACES];

   // output register
   logic                     out_v_ff;
   logic                     out_hit_ff,  out_hit_in;
   logic        [EXT_W-1:0]  out_near_ff, out_near_in;
   logic signed [DATA_W-1:0] out_px_ff,   out_px_in;
   logic signed [DATA_W-1:0] out_py_ff,   out_py_in;
   logic signed [DATA_W-1:0] out_pz_ff,   out_pz_in;
   logic        [FACE_W-1:0] out_face_ff, out_face_in;

   assign busy      = reset;
   assign csr_ready = 1'b1;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            min_ff[a] <= '0;
            ext_ff[a] <= EXT_RESET;
         end
         tol_ff <= TOL_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIN_X: min_ff[0] <= csr_data;
            CSR_MIN_Y: min_ff[1] <= csr_data;
            CSR_MIN_Z: min_ff[2] <= csr_data;
            CSR_EXT_X: ext_ff[0] <= csr_data[EXT_W-1:0];
            CSR_EXT_Y: ext_ff[1] <= csr_data[EXT_W-1:0];
            CSR_EXT_Z: ext_ff[2] <= csr_data[EXT_W-1:0];
            CSR_TOL:   tol_ff    <= csr_data[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // high corner kept one bit wider, no wrap
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         hi[a] = HI_W'(min_ff[a]) + $signed(HI_W'(ext_ff[a]));
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
      end
      ray1_ff.ox <= req_origin_x;
      ray1_ff.oy <= req_origin_y;
      ray1_ff.oz <= req_origin_z;
      ray1_ff.dx <= req_dir_x;
      ray1_ff.dy <= req_dir_y;
      ray1_ff.dz <= req_dir_z;
      near1_ff   <= req_nearest_in;
   end

   assign org1[0] = ray1_ff.ox;
   assign org1[1] = ray1_ff.oy;
   assign org1[2] = ray1_ff.oz;
   assign dir1[0] = ray1_ff.dx;
   assign dir1[1] = ray1_ff.dy;
   assign dir1[2] = ray1_ff.dz;

   // slab distances: face a is the low plane, face a+3 the high plane
   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      logic signed [NUM_W-1:0] num_lo;
      logic signed [NUM_W-1:0] num_hi;
      assign num_lo = NUM_W'(min_ff[a]) - NUM_W'(org1[a]);
      assign num_hi = NUM_W'(hi[a]) - NUM_W'(org1[a]);

      rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
         .clock (clock),
         .num   (num_lo),
         .den   (dir1[a]),
         .quo   (t_div[a])
      );

      rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
         .clock (clock),
         .num   (num_hi),
         .den   (dir1[a]),
         .quo   (t_div[a+NUM_AXES])
      );
   end

   // ray data rides along the divider
   always_ff @(posedge clock) begin
      ray_pipe_ff[0] <= ray1_ff;
      for (int s = 1; s < DIV_LAT; s++) begin
         ray_pipe_ff[s] <= ray_pipe_ff[s-1];
      end
      near_pipe_ff[0] <= near1_ff;
      for (int s = 1; s < NL; s++) begin
         near_pipe_ff[s] <= near_pipe_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NL; s++) begin
            v_pipe_ff[s] <= 1'b0;
         end
      end else begin
         v_pipe_ff[0] <= v1_ff;
         for (int s = 1; s < NL; s++) begin
            v_pipe_ff[s] <= v_pipe_ff[s-1];
         end
      end
   end

   // zero direction skips both planes of that axis
   assign axis_ok[0] = ray_pipe_ff[DIV_LAT-1].dx != '0;
   assign axis_ok[1] = ray_pipe_ff[DIV_LAT-1].dy != '0;
   assign axis_ok[2] = ray_pipe_ff[DIV_LAT-1].dz != '0;

   for (genvar f = 0; f < NUM_FACES; f++) begin : g_face
      rbsi_face #(.FRAC_BITS(FRAC_BITS)) u_face (
         .clock (clock),
         .ok    (axis_ok[f % NUM_AXES]),
         .t     (t_div[f]),
         .ray   (ray_pipe_ff[DIV_LAT-1]),
         .lo    (min_ff),
         .hi    (hi),
         .tol   (tol_ff),
         .res   (face_res[f])
      );
   end

   // faces in index order, later faces need a strictly smaller distance
   always_comb begin
      out_hit_in  = 1'b0;
      out_near_in = near_pipe_ff[NL-1];
      out_px_in   = '0;
      out_py_in   = '0;
      out_pz_in   = '0;
      out_face_in = '0;
      for (int f = 0; f < NUM_FACES; f++) begin
         if (face_res[f].cand && ({1'b0, face_res[f].t[EXT_W-1:0]} < {1'b0, out_near_in})) begin
            out_hit_in  = 1'b1;
            out_near_in = face_res[f].t[EXT_W-1:0];
            out_px_in   = face_res[f].px;
            out_py_in   = face_res[f].py;
            out_pz_in   = face_res[f].pz;
            out_face_in = FACE_W'(f);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= v_pipe_ff[NL-1];
      end
      out_hit_ff  <= out_hit_in;
      out_near_ff <= out_near_in;
      out_px_ff   <= out_px_in;
      out_py_ff   <= out_py_in;
      out_pz_ff   <= out_pz_in;
      out_face_ff <= out_face_in;
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_hit         = out_hit_ff;
   assign rsp_nearest_out = out_near_ff;
   assign rsp_point_x     = out_px_ff;
   assign rsp_point_y     = out_py_ff;
   assign rsp_point_z     = out_pz_ff;
   assign rsp_face        = out_face_ff;

   // every accepted ray gives one response a fixed latency later
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(start && !busy, TOTAL_LAT))
      else $error("response does not line up with accepted ray");

   // a miss reports zero point and face
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |->
         rsp_point_x == '0 && rsp_point_y == '0 && rsp_point_z == '0 && rsp_face == '0)
      else $error("miss with nonzero point or face");

   // a hit names a real face
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_face < FACE_W'(NUM_FACES))
      else $error("hit face out of range");

endmodule

### tb/sv/tb_ray_box_slab_intersect.sv
`timescale 1ns / 1ps

module tb_ray_box_slab_intersect;
   import rbsi_pkg::*;

   localparam int FRAC  = FRAC_BITS_DEF;
   localparam longint U = 64'sd1 << FRAC;          // 1.0 in fixed point
   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;
   localparam int STALL_LIMIT = 10000;              // cycles without any transaction
   localparam int RAYS_PER_BOX = 300;

   // expected response of one ray
   typedef struct {
      bit                     hit;
      bit        [EXT_W-1:0]  nearest;
      bit signed [DATA_W-1:0] px;
      bit signed [DATA_W-1:0] py;
      bit signed [DATA_W-1:0] pz;
      bit        [FACE_W-1:0] face;
   } hit_result_type;

   function automatic longint clamp32(longint v);
      if (v > S32_MAX) return S32_MAX;
      if (v < S32_MIN) return S32_MIN;
      return v;
   endfunction

   // keeps a private copy of the box registers, predicts each ray's response and
   // checks the responses in order
   class hit_scoreboard_type;
      longint box_lo[NUM_AXES];
      longint box_ext[NUM_AXES];
      longint tol;
      hit_result_type pending_hits[$];
      int errors;
      int rays;
      int hits;

      function new();
         foreach (box_lo[a]) begin
            box_lo[a]  = 0;
            box_ext[a] = longint'(EXT_RESET);
         end
         tol = longint'(TOL_RESET);
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [DATA_W-1:0] v);
         case (idx)
            CSR_MIN_X: box_lo[0] = longint'(signed'(v));
            CSR_MIN_Y: box_lo[1] = longint'(signed'(v));
            CSR_MIN_Z: box_lo[2] = longint'(signed'(v));
            CSR_EXT_X: box_ext[0] = longint'(v[EXT_W-1:0]);
            CSR_EXT_Y: box_ext[1] = longint'(v[EXT_W-1:0]);
            CSR_EXT_Z: box_ext[2] = longint'(v[EXT_W-1:0]);
            CSR_TOL:   tol = longint'(v[TOL_W-1:0]);
            default: ;
         endcase
      endfunction

      // ((plane - origin) << FRAC) / dir, truncated toward zero, saturated
      function longint slab_dist(longint num, longint den);
         return clamp32((num <<< FRAC) / den);
      endfunction

      // origin + floor(t * dir / 2^FRAC), saturated
      function longint hit_coord(longint o, longint t, longint d);
         return clamp32(o + ((t * d) >>> FRAC));
      endfunction

      function hit_result_type nearest_face_hit(ray_type r, bit [EXT_W-1:0] near_in);
         hit_result_type res;
         longint o[NUM_AXES], d[NUM_AXES], hi[NUM_AXES], t[NUM_FACES], q[NUM_AXES];
         longint nearest;
         bit in_box;
         int ax;
         o = '{longint'(r.ox), longint'(r.oy), longint'(r.oz)};
         d = '{longint'(r.dx), longint'(r.dy), longint'(r.dz)};
         res = '{default: 0};
         nearest = longint'(near_in);
         for (int a = 0; a < NUM_AXES; a++) begin
            hi[a] = box_lo[a] + box_ext[a];
            t[a] = 0;
            t[a+3] = 0;
            if (d[a] != 0) begin
               t[a]   = slab_dist(box_lo[a] - o[a], d[a]);
               t[a+3] = slab_dist(hi[a] - o[a], d[a]);
            end
         end
         // faces in index order; ties keep the lower index
         for (int f = 0; f < NUM_FACES; f++) begin
            ax = f % NUM_AXES;
            if (d[ax] == 0 || t[f] <= 0) continue;
            in_box = 1;
            for (int a = 0; a < NUM_AXES; a++) begin
               q[a] = hit_coord(o[a], t[f], d[a]);
               if (!(q[a] > box_lo[a] - tol && q[a] < hi[a] + tol)) in_box = 0;
            end
            if (in_box && t[f] < nearest) begin
               nearest  = t[f];
               res.hit  = 1;
               res.px   = DATA_W'(q[0]);
               res.py   = DATA_W'(q[1]);
               res.pz   = DATA_W'(q[2]);
               res.face = FACE_W'(f);
            end
         end
         res.nearest = nearest[EXT_W-1:0];
         return res;
      endfunction

      function void note_ray(ray_type r, bit [EXT_W-1:0] near_in);
         hit_result_type e;
         e = nearest_face_hit(r, near_in);
         pending_hits.push_back(e);
         rays++;
         if (e.hit) hits++;
      endfunction

      function void field_check(string name, longint e, longint a);
         if (e != a) begin
            errors++;
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, e, a);
         end
      endfunction

      function void check_result(hit_result_type a);
         hit_result_type e;
         if (pending_hits.size() == 0) begin
            errors++;
            $display("%0t response with no ray outstanding: expected none actual hit=%0d",
                     $time, a.hit);
            return;
         end
         e = pending_hits.pop_front();
         field_check("hit", e.hit, a.hit);
         field_check("nearest_out", e.nearest, a.nearest);
         field_check("point_x", e.px, a.px);
         field_check("point_y", e.py, a.py);
         field_check("point_z", e.pz, a.pz);
         field_check("face", e.face, a.face);
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic signed [DATA_W-1:0]    req_origin_x, req_origin_y, req_origin_z;
   logic signed [DATA_W-1:0]    req_dir_x, req_dir_y, req_dir_z;
   logic        [EXT_W-1:0]     req_nearest_in;
   logic                        rsp_valid;
   logic                        rsp_hit;
   logic        [EXT_W-1:0]     rsp_nearest_out;
   logic signed [DATA_W-1:0]    rsp_point_x, rsp_point_y, rsp_point_z;
   logic        [FACE_W-1:0]    rsp_face;
   logic                        csr_valid;
   logic                        csr_ready;
   logic        [CSR_IDX_W-1:0] csr_index;
   logic        [DATA_W-1:0]    csr_data;

   hit_scoreboard_type sb = new();
   int sender_idle_pct;
   int stall_cycles;
   int csr_writes;

   ray_box_slab_intersect dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_origin_x    (req_origin_x),
      .req_origin_y    (req_origin_y),
      .req_origin_z    (req_origin_z),
      .req_dir_x       (req_dir_x),
      .req_dir_y       (req_dir_y),
      .req_dir_z       (req_dir_z),
      .req_nearest_in  (req_nearest_in),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_nearest_out (rsp_nearest_out),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_point_z     (rsp_point_z),
      .rsp_face        (rsp_face),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // 4 ns clock, first rising edge at 2 ns
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // ray transactions are noted as they are taken, responses checked as they appear;
   // sampling at the edge sees the values of the cycle that just ended
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            sb.note_ray('{ox: req_origin_x, oy: req_origin_y, oz: req_origin_z,
                          dx: req_dir_x, dy: req_dir_y, dz: req_dir_z}, req_nearest_in);
         end
         if (rsp_valid) begin
            sb.check_result('{hit: rsp_hit, nearest: rsp_nearest_out, px: rsp_point_x,
                              py: rsp_point_y, pz: rsp_point_z, face: rsp_face});
         end
      end
   end

   // watchdog: any transaction on any channel counts as progress
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // one ray transaction; start stays high afterwards unless the next call idles
   task automatic send_ray(ray_type r, bit [EXT_W-1:0] near_in);
      bit free;
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_origin_x   <= r.ox;
      req_origin_y   <= r.oy;
      req_origin_z   <= r.oz;
      req_dir_x      <= r.dx;
      req_dir_y      <= r.dy;
      req_dir_z      <= r.dz;
      req_nearest_in <= near_in;
      // busy only moves on an edge, so the mid-cycle value holds at the next edge
      do begin
         @(negedge clock);
         free = !busy;
         @(posedge clock);
      end while (!free);
   endtask

   // stop sending and let the pipeline empty out
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending_hits.size() != 0) @(posedge clock);
      repeat (TOTAL_LAT + 4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [DATA_W-1:0] v);
      bit done;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do begin
         @(negedge clock);
         done = csr_ready;
         @(posedge clock);
      end while (!done);
      csr_valid <= 1'b0;
      sb.set_reg(idx, v);
      csr_writes++;
   endtask

   task automatic set_box(longint mx, longint my, longint mz,
                          longint ex, longint ey, longint ez, longint tl);
      write_csr(CSR_MIN_X, mx[DATA_W-1:0]);
      write_csr(CSR_MIN_Y, my[DATA_W-1:0]);
      write_csr(CSR_MIN_Z, mz[DATA_W-1:0]);
      write_csr(CSR_EXT_X, ex[DATA_W-1:0]);
      write_csr(CSR_EXT_Y, ey[DATA_W-1:0]);
      write_csr(CSR_EXT_Z, ez[DATA_W-1:0]);
      write_csr(CSR_TOL, tl[DATA_W-1:0]);
   endtask

   function automatic ray_type mk_ray(longint ox, longint oy, longint oz,
                                      longint dx, longint dy, longint dz);
      ray_type r;
      r.ox = ox[DATA_W-1:0];
      r.oy = oy[DATA_W-1:0];
      r.oz = oz[DATA_W-1:0];
      r.dx = dx[DATA_W-1:0];
      r.dy = dy[DATA_W-1:0];
      r.dz = dz[DATA_W-1:0];
      return r;
   endfunction

   function automatic longint rand_s32();
      return longint'(signed'(32'($urandom())));
   endfunction

   // ray from a random origin toward a point in or near the box
   function automatic ray_type aimed_ray();
      longint tgt[NUM_AXES], o[NUM_AXES], d[NUM_AXES];
      longint span;
      int sh;
      sh = $urandom_range(4);
      for (int a = 0; a < NUM_AXES; a++) begin
         tgt[a] = sb.box_lo[a] + (sb.box_ext[a] * $urandom_range(1024)) / 1024
                  + $signed($urandom_range(2 * sb.tol + 4)) - sb.tol - 2;
         span = 64'sd1 << $urandom_range(31, 12);
         o[a] = clamp32(tgt[a] + (rand_s32() % span));
         d[a] = clamp32(tgt[a] - o[a]) >>> sh;
         if (d[a] == 0) d[a] = $urandom_range(1) ? 1 : -1;
      end
      // sometimes run parallel to a pair of planes
      if ($urandom_range(4) == 0) d[$urandom_range(2)] = 0;
      return mk_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
   endfunction

   function automatic bit [EXT_W-1:0] rand_nearest();
      case ($urandom_range(3))
         0, 1:    return '1;
         2:       return EXT_W'($urandom());
         default: return EXT_W'($urandom_range(4 * U));
      endcase
   endfunction

   task automatic random_rays(int count);
      ray_type r;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 80) r = aimed_ray();
         else r = mk_ray(rand_s32(), rand_s32(), rand_s32(),
                         rand_s32(), rand_s32(), rand_s32());
         send_ray(r, rand_nearest());
      end
   endtask

   function automatic longint rand_ext();
      return longint'($urandom_range(16 * U, 1));
   endfunction

   initial begin
      reset = 1'b1;
      start = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_origin_x = '0;
      req_origin_y = '0;
      req_origin_z = '0;
      req_dir_x = '0;
      req_dir_y = '0;
      req_dir_z = '0;
      req_nearest_in = '0;
      sender_idle_pct = 11;
      csr_writes = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rays against the reset box [0,1)^3 with tolerance 66
      send_ray(mk_ray(-U, U/2, U/2, U, 0, 0), '1);        // min x face
      send_ray(mk_ray(2*U, U/2, U/2, -U, 0, 0), '1);      // max x face
      send_ray(mk_ray(U/2, -U, U/2, 0, U, 0), '1);        // min y face
      send_ray(mk_ray(U/2, U/2, 2*U, 0, 0, -U), '1);      // max z face
      send_ray(mk_ray(U/2, U/2, U/2, U, U, U), '1);       // inside, tie on max faces
      send_ray(mk_ray(-U, -U, -U, U, U, U), '1);          // corner, tie on min faces
      send_ray(mk_ray(2*U, U/2, U/2, U, 0, 0), '1);       // box behind the ray
      send_ray(mk_ray(U/2, U/2, U/2, 0, 0, 0), '1);       // all axes skipped
      send_ray(mk_ray(-U, U/2, U/2, U, 0, 0), '0);        // nothing is nearer than zero
      send_ray(mk_ray(-U, U/2, U/2, U, 0, 0), EXT_W'(U)); // equal to nearest, not taken
      send_ray(mk_ray(-U, U+65, U/2, U, 0, 0), '1);       // just inside the tolerance
      send_ray(mk_ray(-U, U+66, U/2, U, 0, 0), '1);       // on the tolerance edge
      send_ray(mk_ray(-U, -65, U/2, U, 0, 0), '1);
      send_ray(mk_ray(-U, -66, U/2, U, 0, 0), '1);
      send_ray(mk_ray(S32_MAX, S32_MAX, S32_MAX, S32_MIN, S32_MIN, S32_MIN), '1);
      send_ray(mk_ray(S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX), '1);
      send_ray(mk_ray(-U, U/2, U/2, 1, 0, 0), '1);        // tiny step, distance saturates
      send_ray(mk_ray(S32_MIN, U/2, U/2, S32_MAX, 1, -1), '1);
      send_ray(mk_ray(0, 0, 0, S32_MIN, S32_MIN, 1), '1);

      // pipeline must be empty before any register write
      drain();

      // box settings: random small, widest, degenerate at the top, random wide, ...
      for (int p = 0; p < 6; p++) begin
         sender_idle_pct = (p < 2) ? 11 : (p < 4) ? 55 : 0;
         case (p)
            0: set_box($signed($urandom_range(16 * U)) - 8 * U,
                       $signed($urandom_range(16 * U)) - 8 * U,
                       $signed($urandom_range(16 * U)) - 8 * U,
                       rand_ext(), rand_ext(), rand_ext(), $urandom_range(256));
            1: set_box(S32_MIN, S32_MIN, S32_MIN, 2147483647, 2147483647, 2147483647,
                       65535);
            2: set_box(S32_MAX, S32_MAX, S32_MAX, 0, 0, 0, 0);
            3: set_box(rand_s32(), rand_s32(), rand_s32(), $urandom_range(2147483647),
                       $urandom_range(2147483647), $urandom_range(2147483647),
                       $urandom_range(65535));
            4: set_box(-U, -2*U, 3*U, rand_ext(), rand_ext(), rand_ext(), 66);
            default: set_box($signed($urandom_range(4 * U)) - 2 * U, 0, -U,
                             0, U/4, 0, $urandom_range(65535));
         endcase
         random_rays(RAYS_PER_BOX / 2);
         // hold off new rays until every response is back, then continue
         drain();
         random_rays(RAYS_PER_BOX / 2);
         drain();
      end

      $display("rays sent: %0d, box hits: %0d, register writes: %0d, six box settings",
               sb.rays, sb.hits, csr_writes);
      $display("covered sender gaps of 11%%, 55%% and none, idle drains between phases");
      if (sb.errors == 0 && sb.pending_hits.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### files.f
design/rbsi_pkg.sv
design/rbsi_div.sv
design/rbsi_face.sv
design/ray_box_slab_intersect.sv
tb/sv/tb_ray_box_slab_intersect.sv
